@@ design/bubble_sort_ascending_unit_defines.svh @@
// Assertion macros of the bubble sort unit.
// Used by bsa_dpath to check its logic; depends on a clk and rst in scope.
`ifndef BUBBLE_SORT_ASCENDING_UNIT_DEFINES_SVH
`define BUBBLE_SORT_ASCENDING_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/bsa_pkg.sv @@
// Package of the bubble sort unit: sizes, item structs, the command struct
// from controller to datapath and the status struct back. Depends on nothing.
package bsa_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value_res;
    logic                     last_res;
    logic                     overflow;
  } out_item_t;

  typedef struct packed {
    logic             load;        // take the input item into the store
    logic             rd_en;       // registered read of the store
    logic [IDX_W-1:0] rd_addr;
    logic             take_carry;  // carry takes the read data
    logic             step;        // compare carry against read data, write back
    logic             wr_final;    // write carry at the end of a pass
    logic [IDX_W-1:0] wr_addr;
    logic             out_load;    // load the result register from read data
    logic             out_last;
    logic             clear_set;   // empty the store for the next set
  } dp_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             gt;          // carry is greater than read data
    logic             out_free;    // result register can take a new item
  } dp_stat_t;

endpackage

@@ design/bubble_sort_ascending_unit.sv @@
// Top level of the bubble sort unit: joins the controller and the datapath.
// Depends on bsa_pkg, bsa_ctrl and bsa_dpath.
//
// The unit collects signed 32-bit elements, one per input item, into a store
// of DEPTH entries, and the item marked last closes the set. The stored
// elements are then sorted into ascending signed order and sent out as result
// items, the final one marked by last_res. Elements that arrive while the
// store is full are dropped, and every result of that set carries overflow.
// Loading takes input items back to back while they are valid. The sort runs
// over the single store memory, one read and one write per cycle: each pass
// carries the largest element seen so far in a register to the end of the
// stored elements, and passes repeat until one makes no swap. Emission
// starts with a read of the first element and then gives one result per
// cycle while the sink is ready. A set thus passes through loading, a start
// state after the last item, the sort, the first read and emission. Input
// items are refused while a set is sorted or emitted; the next set may start
// loading as soon as the final result of the previous set sits in the result
// register.
module bubble_sort_ascending_unit import bsa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      elem_valid,
  output logic      elem_ready,
  input  in_item_t  elem,
  output logic      res_valid,
  input  logic      res_ready,
  output out_item_t res
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bsa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .elem_valid (elem_valid),
    .elem_last  (elem.last),
    .stat       (stat),
    .elem_ready (elem_ready),
    .cmd        (cmd)
  );

  bsa_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .elem      (elem),
    .cmd       (cmd),
    .res_ready (res_ready),
    .stat      (stat),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule

@@ design/bsa_dpath.sv @@
// Datapath of the bubble sort unit: element store, carry register and
// result register. Depends on bsa_pkg and the assertion macro header.
`include "bubble_sort_ascending_unit_defines.svh"

module bsa_dpath import bsa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  elem,
  input  dp_cmd_t   cmd,
  input  logic      res_ready,
  output dp_stat_t  stat,
  output logic      res_valid,
  output out_item_t res
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata;
  logic signed [DATA_W-1:0] carry;
  logic [CNT_W-1:0]         count;
  logic                     dropped;
  logic                     full;
  logic                     gt;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_idx;
  logic signed [DATA_W-1:0] wr_data;

  assign full = (count >= CNT_W'(DEPTH));
  assign gt   = (carry > rdata);

  // One write port, shared by loading and by the sort passes.
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = cmd.wr_addr;
    wr_data = carry;
    priority if (cmd.load && !full) begin
      wr_en   = 1'b1;
      wr_idx  = count[IDX_W-1:0];
      wr_data = elem.value;
    end else if (cmd.step) begin
      wr_en   = 1'b1;
      wr_data = gt ? rdata : carry;
    end else if (cmd.wr_final) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[cmd.rd_addr];
    end
  end

  // The carry holds the largest element seen so far in a pass.
  always_ff @(posedge clk) begin
    if (cmd.take_carry || (cmd.step && !gt)) begin
      carry <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.clear_set) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        dropped <= 1'b1;
      end else begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res.value_res <= rdata;
      res.last_res  <= cmd.out_last;
      res.overflow  <= dropped;
    end
  end

  assign stat.count    = count;
  assign stat.gt       = gt;
  assign stat.out_free = !res_valid || res_ready;

  `BSA_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(DEPTH), "store count above depth")
  `BSA_ASSERT_NOW(a_load_alone, cmd.load, !(cmd.step || cmd.wr_final || cmd.out_load),
                  "load overlaps sort or emission")
  `BSA_ASSERT_NOW(a_out_free, cmd.out_load, !res_valid || res_ready,
                  "result register overwritten while held")
  `BSA_ASSERT_NEXT(a_clear, cmd.clear_set, count == '0 && !dropped, "set not cleared")

endmodule

@@ design/bsa_ctrl.sv @@
// Controller of the bubble sort unit: sequences loading, sort passes and
// emission. Depends on bsa_pkg.
module bsa_ctrl import bsa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     elem_valid,
  input  logic     elem_last,
  input  dp_stat_t stat,
  output logic     elem_ready,
  output dp_cmd_t  cmd
);

  typedef enum logic [6:0] {
    ST_LOAD       = 7'b0000001,
    ST_START      = 7'b0000010,
    ST_SORT_FIRST = 7'b0000100,
    ST_SORT_RUN   = 7'b0001000,
    ST_SORT_END   = 7'b0010000,
    ST_EMIT_RD    = 7'b0100000,
    ST_EMIT_OUT   = 7'b1000000
  } state_t;

  state_t           state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             swapped, swapped_next;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] idx_inc;

  assign last_idx   = IDX_W'(stat.count - CNT_W'(1));
  assign idx_inc    = idx + IDX_W'(1);
  assign elem_ready = (state == ST_LOAD);

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    swapped_next = swapped;
    cmd          = '0;
    unique case (state)
      ST_LOAD: begin
        if (elem_valid) begin
          cmd.load = 1'b1;
          if (elem_last) begin
            state_next = ST_START;
          end
        end
      end
      ST_START: begin
        idx_next = '0;
        if (stat.count < CNT_W'(2)) begin
          state_next = ST_EMIT_RD;
        end else begin
          state_next = ST_SORT_FIRST;
        end
      end
      ST_SORT_FIRST: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_addr  = '0;
        idx_next     = '0;
        swapped_next = 1'b0;
        state_next   = ST_SORT_RUN;
      end
      ST_SORT_RUN: begin
        if (idx == '0) begin
          cmd.take_carry = 1'b1;
        end else begin
          cmd.step    = 1'b1;
          cmd.wr_addr = idx - IDX_W'(1);
          if (stat.gt) begin
            swapped_next = 1'b1;
          end
        end
        if (idx == last_idx) begin
          state_next = ST_SORT_END;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = idx_inc;
          idx_next    = idx_inc;
        end
      end
      ST_SORT_END: begin
        cmd.wr_final = 1'b1;
        cmd.wr_addr  = last_idx;
        idx_next     = '0;
        if (swapped) begin
          state_next = ST_SORT_FIRST;
        end else begin
          state_next = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = idx;
        state_next  = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = (idx == last_idx);
          if (idx == last_idx) begin
            cmd.clear_set = 1'b1;
            state_next    = ST_LOAD;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = idx_inc;
            idx_next    = idx_inc;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      idx     <= '0;
      swapped <= 1'b0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      swapped <= swapped_next;
    end
  end

endmodule
